/* design/sawt_pkg.sv */
package sawt_pkg;

  // fixed field widths
  localparam int ID_W   = 10;
  localparam int TO_W   = 24;
  localparam int TIME_W = 32;
  localparam int CNT_W  = 6;

  typedef enum logic [1:0] {
    ACT_INSERT,
    ACT_CHANGE,
    ACT_REMOVE,
    ACT_TICK
  } action_e;

  typedef enum logic [1:0] {
    KIND_STATUS,
    KIND_EXPIRY,
    KIND_DONE
  } kind_e;

  typedef enum logic [1:0] {
    STS_OK,
    STS_REFRESH,
    STS_MOVED,
    STS_IGNORED
  } status_e;

  // configuration register indexes
  localparam logic CFG_MAX_TIMEOUT = 1'b0;
  localparam logic CFG_START_TIME  = 1'b1;

  // classified command handed from front to back
  typedef struct packed {
    action_e           action;
    logic [ID_W-1:0]   id;
    logic [TO_W-1:0]   timeout;
    logic              bad;
  } cmd_t;

endpackage

/* design/sawt_ram.sv */
module sawt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* design/sawt_front.sv */
module sawt_front #(
  parameter int SESSION_COUNT = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [39:0]         s_axis_tdata,
  input  logic [1:0]          s_axis_tuser,
  input  logic                busy_i,
  output logic                cmd_valid_o,
  output sawt_pkg::cmd_t      cmd_o,
  input  logic                cmd_pop_i
);

  localparam int QD = 4;

  sawt_pkg::cmd_t fifo_q [QD];
  logic [1:0] wr_q, wr_d, rd_q, rd_d;
  logic [2:0] cnt_q, cnt_d;
  logic       push;
  sawt_pkg::cmd_t in_cmd;

  // classify: out-of-range ids are flagged here
  always_comb begin
    in_cmd.action  = sawt_pkg::action_e'(s_axis_tuser);
    in_cmd.id      = s_axis_tdata[9:0];
    in_cmd.timeout = s_axis_tdata[33:10];
    in_cmd.bad     = (32'(s_axis_tdata[9:0]) >= SESSION_COUNT);
  end

  assign s_axis_tready = (cnt_q != 3'(QD)) && !busy_i;
  assign push          = s_axis_tvalid && s_axis_tready;
  assign cmd_valid_o   = (cnt_q != 3'd0);
  assign cmd_o         = fifo_q[rd_q];

  always_comb begin
    wr_d  = wr_q + 2'(push);
    rd_d  = rd_q + 2'(cmd_pop_i);
    cnt_d = cnt_q + 3'(push) - 3'(cmd_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_q] <= in_cmd;
    end
  end

endmodule

/* design/sawt_back.sv */
module sawt_back #(
  parameter int WHEEL_SLOTS   = 4096,
  parameter int SESSION_COUNT = 1024,
  parameter int EXPIRE_LIMIT  = 63
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  sawt_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  output logic           busy_o,
  input  logic           cfg_we_i,
  input  logic           cfg_idx_i,
  input  logic [31:0]    cfg_wdata_i,
  output logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  output logic [23:0]    m_axis_tdata,
  output logic [1:0]     m_axis_tuser,
  output logic           m_axis_tlast
);

  localparam int IDW  = $clog2(SESSION_COUNT);
  localparam int LW   = $clog2(SESSION_COUNT + 1);
  localparam int SLW  = $clog2(WHEEL_SLOTS);
  localparam int VW   = $clog2(SESSION_COUNT + 1);
  localparam int CLRN = (WHEEL_SLOTS > SESSION_COUNT) ? WHEEL_SLOTS : SESSION_COUNT;
  localparam int CLRW = $clog2(CLRN);
  localparam int EW   = sawt_pkg::TO_W + sawt_pkg::TIME_W + SLW + 2;
  localparam logic [LW-1:0] NIL = LW'(SESSION_COUNT);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_LD    = 4'd2;
  localparam logic [3:0] S_DET   = 4'd3;
  localparam logic [3:0] S_ATT   = 4'd4;
  localparam logic [3:0] S_ATT2  = 4'd5;
  localparam logic [3:0] S_ATT3  = 4'd6;
  localparam logic [3:0] S_WENT  = 4'd7;
  localparam logic [3:0] S_EMIT  = 4'd8;
  localparam logic [3:0] S_THEAD = 4'd9;
  localparam logic [3:0] S_THD2  = 4'd10;
  localparam logic [3:0] S_TCHK  = 4'd11;
  localparam logic [3:0] S_TLD   = 4'd12;
  localparam logic [3:0] S_TCALC = 4'd13;
  localparam logic [3:0] S_TNEXT = 4'd14;

  // control state
  logic [3:0]      state_q, state_d, ret_q, ret_d;
  logic [CLRW-1:0] clr_q, clr_d;
  logic [31:0]     now_q, now_d;
  logic [23:0]     maxto_q, maxto_d;
  logic            ov_q, ov_d, in_tick_q, in_tick_d, rep_q, rep_d, att_q, att_d;
  logic [5:0]      cnt_q, cnt_d;
  logic [VW-1:0]   visits_q, visits_d;

  // payload
  logic [IDW-1:0]  s_q, s_d;
  sawt_pkg::action_e act_q, act_d;
  logic [23:0]     nt_q, nt_d, e_to_q, e_to_d;
  logic [31:0]     e_st_q, e_st_d;
  logic [SLW-1:0]  e_sl_q, e_sl_d, tgt_q, tgt_d;
  logic            e_lk_q, e_lk_d, e_ex_q, e_ex_d;
  logic [LW-1:0]   n_q, n_d, p_q, p_d, cur_q, cur_d, nxt_q, nxt_d;
  sawt_pkg::kind_e   r_kind_q, r_kind_d, o_kind_q, o_kind_d;
  sawt_pkg::status_e r_st_q, r_st_d, o_st_q, o_st_d;
  logic [9:0]      r_ref_q, r_ref_d, o_ref_q, o_ref_d;
  logic [5:0]      r_cnt_q, r_cnt_d, o_cnt_q, o_cnt_d;
  logic            r_last_q, r_last_d, o_last_q, o_last_d;

  // memory ports
  logic            hd_we, nx_we, pv_we, en_we;
  logic [SLW-1:0]  hd_wa, hd_ra;
  logic [LW-1:0]   hd_wd, hd_rd, nx_wd, nx_rd, pv_wd, pv_rd;
  logic [IDW-1:0]  nx_wa, pv_wa, en_wa, ss_ra;
  logic [EW-1:0]   en_wd, en_rd;

  // entry record fields as read
  logic [23:0]     rd_to;
  logic [31:0]     rd_st;
  logic [SLW-1:0]  rd_sl;
  logic            rd_lk, rd_ex;
  assign {rd_to, rd_st, rd_sl, rd_lk, rd_ex} = en_rd;

  logic [31:0] id32, s32, now_nt, age, due;
  logic [SLW-1:0] tgt_a;
  logic [23:0] clamp;
  assign id32   = 32'(cmd_i.id);
  assign s32    = 32'(s_q);
  assign clamp  = (cmd_i.timeout > maxto_q) ? maxto_q : cmd_i.timeout;
  assign now_nt = now_q + 32'(nt_q);
  assign age    = now_q - e_st_q;
  assign due    = e_st_q + 32'(e_to_q);
  assign tgt_a  = due[SLW-1:0];

  sawt_ram #(.WIDTH(LW), .DEPTH(WHEEL_SLOTS)) u_head (
    .clk_i(clk_i), .we_i(hd_we), .waddr_i(hd_wa), .wdata_i(hd_wd),
    .raddr_i(hd_ra), .rdata_o(hd_rd));
  sawt_ram #(.WIDTH(LW), .DEPTH(SESSION_COUNT)) u_next (
    .clk_i(clk_i), .we_i(nx_we), .waddr_i(nx_wa), .wdata_i(nx_wd),
    .raddr_i(ss_ra), .rdata_o(nx_rd));
  sawt_ram #(.WIDTH(LW), .DEPTH(SESSION_COUNT)) u_prev (
    .clk_i(clk_i), .we_i(pv_we), .waddr_i(pv_wa), .wdata_i(pv_wd),
    .raddr_i(ss_ra), .rdata_o(pv_rd));
  sawt_ram #(.WIDTH(EW), .DEPTH(SESSION_COUNT)) u_entry (
    .clk_i(clk_i), .we_i(en_we), .waddr_i(en_wa), .wdata_i(en_wd),
    .raddr_i(ss_ra), .rdata_o(en_rd));

  assign cmd_pop_o = (state_q == S_IDLE) && cmd_valid_i;
  assign busy_o    = (state_q == S_CLR);

  // sequencer
  always_comb begin
    state_d = state_q;  ret_d = ret_q;  clr_d = clr_q;  now_d = now_q;
    maxto_d = maxto_q;  ov_d = ov_q;  in_tick_d = in_tick_q;  rep_d = rep_q;
    att_d = att_q;  cnt_d = cnt_q;  visits_d = visits_q;
    s_d = s_q;  act_d = act_q;  nt_d = nt_q;  e_to_d = e_to_q;  e_st_d = e_st_q;
    e_sl_d = e_sl_q;  e_lk_d = e_lk_q;  e_ex_d = e_ex_q;  tgt_d = tgt_q;
    n_d = n_q;  p_d = p_q;  cur_d = cur_q;  nxt_d = nxt_q;
    r_kind_d = r_kind_q;  r_st_d = r_st_q;  r_ref_d = r_ref_q;
    r_cnt_d = r_cnt_q;  r_last_d = r_last_q;
    o_kind_d = o_kind_q;  o_st_d = o_st_q;  o_ref_d = o_ref_q;
    o_cnt_d = o_cnt_q;  o_last_d = o_last_q;
    hd_we = 1'b0;  hd_wa = tgt_q;  hd_wd = n_q;  hd_ra = tgt_q;
    nx_we = 1'b0;  nx_wa = s_q;  nx_wd = n_q;
    pv_we = 1'b0;  pv_wa = s_q;  pv_wd = NIL;
    en_we = 1'b0;  en_wa = s_q;  en_wd = {e_to_q, e_st_q, e_sl_q, e_lk_q, e_ex_q};
    ss_ra = s_q;

    if (ov_q && m_axis_tready) begin
      ov_d = 1'b0;
    end

    unique case (state_q)
      S_CLR: begin
        hd_wa = clr_q[SLW-1:0];
        hd_wd = NIL;
        hd_we = (32'(clr_q) < WHEEL_SLOTS);
        en_wa = clr_q[IDW-1:0];
        en_wd = '0;
        en_we = (32'(clr_q) < SESSION_COUNT);
        clr_d = clr_q + 1'b1;
        if (32'(clr_q) == CLRN - 1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd_valid_i) begin
          act_d     = cmd_i.action;
          nt_d      = clamp;
          s_d       = id32[IDW-1:0];
          ss_ra     = id32[IDW-1:0];
          in_tick_d = 1'b0;
          r_kind_d  = sawt_pkg::KIND_STATUS;
          r_ref_d   = cmd_i.id;
          r_cnt_d   = '0;
          r_last_d  = 1'b1;
          ret_d     = S_IDLE;
          if (cmd_i.action == sawt_pkg::ACT_TICK) begin
            now_d     = now_q + 32'd1;
            in_tick_d = 1'b1;
            cnt_d     = '0;
            visits_d  = '0;
            state_d   = S_THEAD;
          end else if (cmd_i.bad) begin
            r_st_d  = sawt_pkg::STS_IGNORED;
            state_d = S_EMIT;
          end else begin
            state_d = S_LD;
          end
        end
      end
      S_LD: begin
        e_to_d = rd_to;  e_st_d = rd_st;  e_sl_d = rd_sl;
        e_lk_d = rd_lk;  e_ex_d = rd_ex;
        n_d = nx_rd;  p_d = pv_rd;
        r_st_d = sawt_pkg::STS_OK;
        tgt_d  = now_nt[SLW-1:0];
        case (act_q)
          sawt_pkg::ACT_INSERT: begin
            e_to_d = nt_q;  e_st_d = now_q;  e_ex_d = 1'b0;
            att_d = 1'b1;  state_d = S_DET;
          end
          sawt_pkg::ACT_REMOVE: begin
            e_ex_d = 1'b1;  att_d = 1'b0;  state_d = S_DET;
          end
          default: begin
            if (rd_ex || !rd_lk) begin
              r_st_d  = sawt_pkg::STS_IGNORED;
              state_d = S_EMIT;
            end else begin
              state_d = S_WENT;
              if (!(now_q == rd_st && nt_q == rd_to)) begin
                if (now_q != rd_st) begin
                  e_st_d = now_q;
                  r_st_d = sawt_pkg::STS_REFRESH;
                end
                if (nt_q == '0) begin
                  e_to_d = '0;
                end else if (nt_q != rd_to) begin
                  e_to_d = nt_q;
                  r_st_d = sawt_pkg::STS_MOVED;
                  if (rd_sl != now_nt[SLW-1:0]) begin
                    att_d   = 1'b1;
                    state_d = S_DET;
                  end
                end
              end
            end
          end
        endcase
      end
      // unlink s using captured neighbors
      S_DET: begin
        if (e_lk_q) begin
          if (p_q == NIL) begin
            hd_we = 1'b1;  hd_wa = e_sl_q;  hd_wd = n_q;
          end else begin
            nx_we = 1'b1;  nx_wa = p_q[IDW-1:0];  nx_wd = n_q;
          end
          if (n_q != NIL) begin
            pv_we = 1'b1;  pv_wa = n_q[IDW-1:0];  pv_wd = p_q;
          end
        end
        e_lk_d  = 1'b0;
        state_d = att_q ? S_ATT : S_WENT;
      end
      S_ATT: begin
        hd_ra   = tgt_q;
        state_d = S_ATT2;
      end
      // link s at the head of the target slot
      S_ATT2: begin
        n_d   = hd_rd;
        nx_we = 1'b1;  nx_wa = s_q;  nx_wd = hd_rd;
        pv_we = 1'b1;  pv_wa = s_q;  pv_wd = NIL;
        hd_we = 1'b1;  hd_wa = tgt_q;  hd_wd = LW'(s32);
        e_sl_d = tgt_q;
        e_lk_d = 1'b1;
        state_d = S_ATT3;
      end
      S_ATT3: begin
        if (n_q != NIL) begin
          pv_we = 1'b1;  pv_wa = n_q[IDW-1:0];  pv_wd = LW'(s32);
        end
        state_d = S_WENT;
      end
      S_WENT: begin
        en_we = 1'b1;
        if (in_tick_q) begin
          state_d = rep_q ? S_EMIT : S_TNEXT;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!ov_q || m_axis_tready) begin
          ov_d     = 1'b1;
          o_kind_d = r_kind_q;  o_st_d = r_st_q;  o_ref_d = r_ref_q;
          o_cnt_d  = r_cnt_q;   o_last_d = r_last_q;
          state_d  = ret_q;
        end
      end
      S_THEAD: begin
        hd_ra   = now_q[SLW-1:0];
        state_d = S_THD2;
      end
      S_THD2: begin
        cur_d   = hd_rd;
        state_d = S_TCHK;
      end
      S_TCHK: begin
        if (cur_q == NIL || visits_q == VW'(SESSION_COUNT) || cnt_q == 6'(EXPIRE_LIMIT)) begin
          r_kind_d = sawt_pkg::KIND_DONE;
          r_ref_d  = '0;
          r_st_d   = sawt_pkg::STS_OK;
          r_cnt_d  = cnt_q;
          r_last_d = 1'b1;
          ret_d    = S_IDLE;
          state_d  = S_EMIT;
        end else begin
          ss_ra   = cur_q[IDW-1:0];
          s_d     = cur_q[IDW-1:0];
          state_d = S_TLD;
        end
      end
      S_TLD: begin
        e_to_d = rd_to;  e_st_d = rd_st;  e_sl_d = rd_sl;
        e_lk_d = rd_lk;  e_ex_d = rd_ex;
        n_d = nx_rd;  p_d = pv_rd;  nxt_d = nx_rd;
        visits_d = visits_q + 1'b1;
        state_d  = S_TCALC;
      end
      // classify the visited session: park, expire or reschedule
      S_TCALC: begin
        rep_d = 1'b0;
        att_d = 1'b1;
        if (e_to_q == '0) begin
          tgt_d = now_q[SLW-1:0] - 1'b1;
          if (e_lk_q && e_sl_q == now_q[SLW-1:0] - 1'b1) begin
            state_d = S_TNEXT;
          end else begin
            state_d = S_DET;
          end
        end else if (age >= 32'(e_to_q)) begin
          e_ex_d   = 1'b1;
          cnt_d    = cnt_q + 1'b1;
          rep_d    = 1'b1;
          att_d    = 1'b0;
          r_kind_d = sawt_pkg::KIND_EXPIRY;
          r_ref_d  = s32[9:0];
          r_st_d   = sawt_pkg::STS_OK;
          r_cnt_d  = cnt_q + 1'b1;
          r_last_d = 1'b0;
          ret_d    = S_TNEXT;
          state_d  = S_DET;
        end else begin
          tgt_d = (e_sl_q == tgt_a) ? tgt_a - 1'b1 : tgt_a;
          if (e_lk_q && e_sl_q != tgt_a && e_sl_q == tgt_a) begin
            state_d = S_TNEXT;
          end else begin
            state_d = S_DET;
          end
        end
      end
      S_TNEXT: begin
        cur_d   = nxt_q;
        state_d = S_TCHK;
      end
      default: state_d = S_IDLE;
    endcase

    // configuration writes
    if (cfg_we_i) begin
      if (cfg_idx_i == sawt_pkg::CFG_MAX_TIMEOUT) begin
        maxto_d = cfg_wdata_i[23:0];
      end else begin
        now_d = cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLR;
      ret_q     <= S_IDLE;
      clr_q     <= '0;
      now_q     <= 32'd5000;
      maxto_q   <= 24'd86400;
      ov_q      <= 1'b0;
      in_tick_q <= 1'b0;
      rep_q     <= 1'b0;
      att_q     <= 1'b0;
      cnt_q     <= '0;
      visits_q  <= '0;
    end else begin
      state_q   <= state_d;
      ret_q     <= ret_d;
      clr_q     <= clr_d;
      now_q     <= now_d;
      maxto_q   <= maxto_d;
      ov_q      <= ov_d;
      in_tick_q <= in_tick_d;
      rep_q     <= rep_d;
      att_q     <= att_d;
      cnt_q     <= cnt_d;
      visits_q  <= visits_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q <= s_d;  act_q <= act_d;  nt_q <= nt_d;
    e_to_q <= e_to_d;  e_st_q <= e_st_d;  e_sl_q <= e_sl_d;
    e_lk_q <= e_lk_d;  e_ex_q <= e_ex_d;  tgt_q <= tgt_d;
    n_q <= n_d;  p_q <= p_d;  cur_q <= cur_d;  nxt_q <= nxt_d;
    r_kind_q <= r_kind_d;  r_st_q <= r_st_d;  r_ref_q <= r_ref_d;
    r_cnt_q <= r_cnt_d;  r_last_q <= r_last_d;
    o_kind_q <= o_kind_d;  o_st_q <= o_st_d;  o_ref_q <= o_ref_d;
    o_cnt_q <= o_cnt_d;  o_last_q <= o_last_d;
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {6'd0, o_cnt_q, o_st_q, o_ref_q};
  assign m_axis_tuser  = o_kind_q;
  assign m_axis_tlast  = o_last_q;

endmodule

/* design/session_aging_timer_wheel_top.sv */
// Session aging timer wheel.
// Commands arrive on the s_axis stream (tuser = action: insert, change,
// remove, tick). A four-entry queue decouples command intake from the
// sequencer that updates the slot-head, link and entry memories.
// Every insert, change or remove command yields one status transfer; a
// tick yields one expiry report per lapsed session (at most EXPIRE_LIMIT)
// and a closing tick-done transfer with tlast set. Results leave on m_axis,
// tuser = kind. After reset a clearing pass over max(WHEEL_SLOTS,
// SESSION_COUNT) addresses (4096 by default) empties the wheel;
// s_axis_tready stays low meanwhile. Configuration writes are taken at any
// time. If m_axis stalls, one result waits in the output register and the
// sequencer holds, while the input queue keeps taking commands until it
// fills. WHEEL_SLOTS must be a power of two; the block does not check this.
module session_aging_timer_wheel_top #(
  parameter int WHEEL_SLOTS   = 4096,
  parameter int SESSION_COUNT = 1024,
  parameter int EXPIRE_LIMIT  = 63
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // session_id[9:0], timeout[33:10]
  input  logic [1:0]  s_axis_tuser,   // action[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // session_ref[9:0], status[11:10], expired_count[17:12]
  output logic [1:0]  m_axis_tuser,   // result_kind[1:0]
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_wdata_i
);

  logic           clr_busy, cmd_valid, cmd_pop;
  sawt_pkg::cmd_t cmd;

  sawt_front #(.SESSION_COUNT(SESSION_COUNT)) u_front (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .busy_i(clr_busy), .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_pop_i(cmd_pop));

  sawt_back #(
    .WHEEL_SLOTS(WHEEL_SLOTS), .SESSION_COUNT(SESSION_COUNT),
    .EXPIRE_LIMIT(EXPIRE_LIMIT)
  ) u_back (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cmd_valid_i(cmd_valid), .cmd_i(cmd), .cmd_pop_o(cmd_pop), .busy_o(clr_busy),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_wdata_i(cfg_wdata_i),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast));

  // no intake while the wheel is being cleared
  a_no_intake_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy |-> !s_axis_tready) else $error("intake open during clearing pass");

  // expiry reports never close an item, tick-done always does
  a_expiry_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == sawt_pkg::KIND_EXPIRY) |-> !m_axis_tlast)
    else $error("expiry report marked last");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == sawt_pkg::KIND_DONE) |-> m_axis_tlast)
    else $error("tick done not marked last");

endmodule
